// ===== rtl/bggm_pkg.sv =====
// Package: shared widths, limits and sequencer states of the gene mutation unit.
package bggm_pkg;

    localparam int GENE_W       = 32;
    localparam int SAMPLE_W     = 16;
    localparam int COUNT_W      = 11;
    localparam int GENOME_MAX   = 1024;
    localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
    localparam int COUNT_CAP    = (GENOME_MAX < COUNT_FIELD_MAX) ? GENOME_MAX : COUNT_FIELD_MAX;

    localparam int PROD_W       = GENE_W + SAMPLE_W;   // exact Q36.12 product
    localparam int FRAC_SHIFT   = 12;                  // Q4.12 sample fraction bits
    localparam int SUM_W        = PROD_W - FRAC_SHIFT + 2;
    localparam int EXC_W        = SUM_W - 1;           // excess is never negative
    localparam int RANGE_W      = GENE_W + 1;
    localparam int STEP_W       = $clog2(EXC_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CMP,
        ST_DIV,
        ST_FIN
    } bggm_state_t;

    typedef struct packed {
        logic in_ready;
        logic mul_en;
        logic add_en;
        logic cmp_en;
        logic div_en;
        logic out_load;
    } bggm_ctrl_t;

endpackage

// ===== rtl/bggm_if.sv =====
// Interfaces: gene input channel and mutated gene output channel.
interface bggm_in_if;
    import bggm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [GENE_W-1:0]   gene_value;
    logic signed [GENE_W-1:0]   deviation;
    logic signed [GENE_W-1:0]   lower_limit;
    logic signed [GENE_W-1:0]   upper_limit;
    logic                       wraps_around;
    logic                       chosen;
    logic signed [SAMPLE_W-1:0] noise_sample;
    logic                       final_gene;

    modport source (
        output valid, gene_value, deviation, lower_limit, upper_limit,
               wraps_around, chosen, noise_sample, final_gene,
        input  ready
    );
    modport sink (
        input  valid, gene_value, deviation, lower_limit, upper_limit,
               wraps_around, chosen, noise_sample, final_gene,
        output ready
    );
endinterface

interface bggm_out_if;
    import bggm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [GENE_W-1:0] new_value;
    logic                     was_chosen;
    logic                     end_of_genome;
    logic [COUNT_W-1:0]       chosen_total;

    modport source (
        output valid, new_value, was_chosen, end_of_genome, chosen_total,
        input  ready
    );
    modport sink (
        input  valid, new_value, was_chosen, end_of_genome, chosen_total,
        output ready
    );
endinterface

// ===== rtl/bounded_gaussian_gene_mutation_unit.sv =====
// Top level: gaussian gene mutation with clamp, reflect or wrap at the bounds.
//
// One gene word enters, one result word leaves, in order. The unit takes a word
// only in its idle state and then works on it step by step: it captures the
// word, runs the 16x32 noise multiply, the add and the bound compare, then the
// shared bit-serial remainder unit (one quotient bit per cycle over the 37-bit
// excess), and last folds and saturates into the output register. The remainder
// loop runs on every word, with a zero excess when no fold is needed, so every
// word takes the same steps. The output register holds a finished word while
// the next gene is captured; the fold step waits there only if the previous
// result is still unread. Chosen genes are counted on capture; the count
// saturates at the genome limit and is reported, then cleared, on the word
// marked as the last gene. The bounce register must be written through cfg_we /
// cfg_wdata by the user only while the unit is idle; the unit does not enforce it.
module bounded_gaussian_gene_mutation_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    bggm_in_if.sink       gene_in,
    bggm_out_if.source    gene_out
);
    import bggm_pkg::*;

    bggm_state_t state_reg, state_next;
    bggm_ctrl_t  ctrl;

    logic bounce_reg;
    logic [COUNT_W-1:0] count_reg;

    // Captured gene word.
    logic signed [GENE_W-1:0]   gene_reg, dev_reg, lo_reg, hi_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic wrap_reg, pick_reg, last_reg;
    logic [COUNT_W-1:0] total_reg;

    // Datapath.
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [GENE_W-1:0]  base_reg;
    logic                      sub_reg;
    logic [EXC_W-1:0]          exc_reg;
    logic [RANGE_W-1:0]        range_reg;
    logic [RANGE_W-1:0]        rem_reg;
    logic [STEP_W-1:0]         step_reg;

    // Output register.
    logic                      out_valid_reg;
    logic signed [GENE_W-1:0]  out_value_reg;
    logic                      out_pick_reg, out_last_reg;
    logic [COUNT_W-1:0]        out_total_reg;

    logic in_fire;
    logic out_free;
    logic active;
    logic [COUNT_W-1:0] count_bumped;

    logic signed [SUM_W-1:0]   gene_ext, lo_ext, hi_ext, noise_term;
    logic signed [RANGE_W-1:0] span;
    logic [RANGE_W-1:0]        span_mag;
    logic                      below, above, folds;
    logic [RANGE_W:0]          trial;
    logic [RANGE_W:0]          trial_diff;
    logic signed [RANGE_W+1:0] fold_sum;
    logic signed [GENE_W-1:0]  fold_sat;

    localparam logic signed [RANGE_W+1:0] INT_MAX_EXT =
        (RANGE_W+2)'(signed'({1'b0, {(GENE_W-1){1'b1}}}));
    localparam logic signed [RANGE_W+1:0] INT_MIN_EXT =
        (RANGE_W+2)'(signed'({1'b1, {(GENE_W-1){1'b0}}}));

    assign in_fire  = gene_in.valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || gene_out.ready;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (gene_in.valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == '0) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_MUL:  ctrl.mul_en   = 1'b1;
            ST_ADD:  ctrl.add_en   = 1'b1;
            ST_CMP:  ctrl.cmp_en   = 1'b1;
            ST_DIV:  ctrl.div_en   = 1'b1;
            ST_FIN:  ctrl.out_load = out_free;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign gene_in.ready = ctrl.in_ready;

    // ------------------------------------------------------ config and counter
    // Saturate the chosen count at the genome limit.
    assign count_bumped = (gene_in.chosen && (count_reg < COUNT_W'(COUNT_CAP)))
                          ? count_reg + COUNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bounce_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                // Clear after the last gene of a genome.
                count_reg <= gene_in.final_gene ? '0 : count_bumped;
            end
        end
    end

    // -------------------------------------------------------------- capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gene_reg   <= gene_in.gene_value;
            dev_reg    <= gene_in.deviation;
            lo_reg     <= gene_in.lower_limit;
            hi_reg     <= gene_in.upper_limit;
            sample_reg <= gene_in.noise_sample;
            wrap_reg   <= gene_in.wraps_around;
            pick_reg   <= gene_in.chosen;
            last_reg   <= gene_in.final_gene;
            total_reg  <= gene_in.final_gene ? count_bumped : '0;
        end
    end

    // ------------------------------------------------------------- datapath
    assign active     = pick_reg && !dev_reg[GENE_W-1] && (dev_reg != '0);
    assign gene_ext   = SUM_W'(gene_reg);
    assign lo_ext     = SUM_W'(lo_reg);
    assign hi_ext     = SUM_W'(hi_reg);
    // Arithmetic shift drops the sample fraction, rounding toward minus infinity.
    assign noise_term = SUM_W'(prod_reg >>> FRAC_SHIFT);

    assign span     = RANGE_W'(hi_reg) - RANGE_W'(lo_reg);
    assign span_mag = span[RANGE_W-1] ? RANGE_W'(-span) : RANGE_W'(span);
    assign below    = sum_reg < lo_ext;
    assign above    = sum_reg > hi_ext;
    assign folds    = (wrap_reg || bounce_reg) && (span_mag != '0);

    // Restoring remainder step: shift in one excess bit, subtract if it fits.
    assign trial      = {rem_reg, exc_reg[EXC_W-1]};
    assign trial_diff = trial - {1'b0, range_reg};

    assign fold_sum = sub_reg ? ((RANGE_W+2)'(base_reg) - (RANGE_W+2)'(signed'({1'b0, rem_reg})))
                              : ((RANGE_W+2)'(base_reg) + (RANGE_W+2)'(signed'({1'b0, rem_reg})));

    always_comb
    begin
        priority if (fold_sum > INT_MAX_EXT)
            fold_sat = INT_MAX_EXT[GENE_W-1:0];
        else if (fold_sum < INT_MIN_EXT)
            fold_sat = INT_MIN_EXT[GENE_W-1:0];
        else
            fold_sat = fold_sum[GENE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(sample_reg) * PROD_W'(dev_reg);
        end
        if (ctrl.add_en)
        begin
            sum_reg <= gene_ext + noise_term;
        end
        if (ctrl.cmp_en)
        begin
            range_reg <= span_mag;
            rem_reg   <= '0;
            step_reg  <= STEP_W'(EXC_W - 1);
            sub_reg   <= 1'b0;
            exc_reg   <= '0;
            priority if (!active)
            begin
                base_reg <= gene_reg;
            end
            else if (below)
            begin
                if (folds)
                begin
                    // Wrap counts down from high, reflect up from low.
                    base_reg <= wrap_reg ? hi_reg : lo_reg;
                    sub_reg  <= wrap_reg;
                    exc_reg  <= EXC_W'(lo_ext - sum_reg);
                end
                else
                begin
                    base_reg <= lo_reg;
                end
            end
            else if (above)
            begin
                if (folds)
                begin
                    base_reg <= wrap_reg ? lo_reg : hi_reg;
                    sub_reg  <= !wrap_reg;
                    exc_reg  <= EXC_W'(sum_reg - hi_ext);
                end
                else if (wrap_reg || bounce_reg)
                begin
                    // Zero range folds to the low bound.
                    base_reg <= lo_reg;
                end
                else
                begin
                    base_reg <= hi_reg;
                end
            end
            else
            begin
                base_reg <= sum_reg[GENE_W-1:0];
            end
        end
        if (ctrl.div_en)
        begin
            rem_reg  <= trial_diff[RANGE_W] ? trial[RANGE_W-1:0] : trial_diff[RANGE_W-1:0];
            exc_reg  <= {exc_reg[EXC_W-2:0], 1'b0};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (gene_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_value_reg <= fold_sat;
            out_pick_reg  <= pick_reg;
            out_last_reg  <= last_reg;
            out_total_reg <= total_reg;
        end
    end

    assign gene_out.valid         = out_valid_reg;
    assign gene_out.new_value     = out_value_reg;
    assign gene_out.was_chosen    = out_pick_reg;
    assign gene_out.end_of_genome = out_last_reg;
    assign gene_out.chosen_total  = out_total_reg;

endmodule

// ===== rtl/bggm_checker.sv =====
// Checker: port-level properties of the gene mutation unit, bound to the top level.
module bggm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   out_last,
    input logic [bggm_pkg::COUNT_W-1:0] out_total
);
    import bggm_pkg::*;

    // A gene word in flight keeps the input closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a gene was accepted");

    // A result not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before it was taken");

    // The count shows only on the last gene.
    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (out_total == '0))
        else $error("chosen total nonzero on a gene that is not the last");

    // The count never passes the genome limit.
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_total <= COUNT_W'(COUNT_CAP)))
        else $error("chosen total above the genome limit");

endmodule

bind bounded_gaussian_gene_mutation_unit bggm_checker u_bggm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gene_in.valid),
    .in_ready  (gene_in.ready),
    .out_valid (gene_out.valid),
    .out_ready (gene_out.ready),
    .out_last  (gene_out.end_of_genome),
    .out_total (gene_out.chosen_total)
);
